@@ hdl/hpss_pkg.sv @@
// ----------------------------------------------------------------------------
// hpss_pkg: shared types and constants of the HMM path site segmenter
// Field widths, state codes, register indexes, queued item and result records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpss_pkg;

	localparam int POS_W      = 16;
	localparam int LOGV_W     = 32;
	localparam int ACC_W      = 40;
	localparam int STEP_W     = 34;
	localparam int WIDE_W     = 42;
	localparam int STATE_W    = 3;
	localparam int BASE_W     = 2;
	localparam int SEQ_W      = 16;
	localparam int NUM_COORDS = 6;
	localparam int TBL_DEPTH  = 16;
	localparam int TBL_IDX_W  = 4;
	localparam int CFG_W      = 32;
	localparam int PADDR_W    = 3;

	// Decoded path states with a special role.
	localparam logic [STATE_W-1:0] S_START       = 3'd0;
	localparam logic [STATE_W-1:0] S_FIRST_COORD = 3'd1;
	localparam logic [STATE_W-1:0] S_LAST        = 3'd6;
	localparam logic [STATE_W-1:0] S_NULL        = 3'd7;

	typedef enum logic {
		CMD_PATH  = 1'b0,
		CMD_TABLE = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_NULL_SELF = 1'b0,
		REG_NULL_INIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [LOGV_W-1:0] null_self;
		logic signed [LOGV_W-1:0] null_init;
	} cfg_t;

	// Path element as it waits between the front and the back.
	typedef struct packed {
		logic [STATE_W-1:0]       state;
		logic signed [LOGV_W-1:0] path_logv;
		logic signed [LOGV_W-1:0] null_logv;
		logic signed [STEP_W-1:0] step;
		logic                     eos;
		logic                     strand;
		logic [SEQ_W-1:0]         seq;
	} elem_t;

	// A finished site before its score is formed.
	typedef struct packed {
		logic [SEQ_W-1:0]                   seq;
		logic                               strand;
		logic [POS_W-1:0]                   first;
		logic [POS_W-1:0]                   last;
		logic signed [LOGV_W-1:0]           path;
		logic signed [ACC_W-1:0]            acc;
		logic [NUM_COORDS-1:0][POS_W-1:0]   coords;
	} emit_t;

	typedef struct packed {
		logic [SEQ_W-1:0]                   seq;
		logic                               strand;
		logic [POS_W-1:0]                   first;
		logic [POS_W-1:0]                   last;
		logic signed [ACC_W-1:0]            score;
		logic [NUM_COORDS-1:0][POS_W-1:0]   coords;
	} result_t;

	// Saturate a wide signed sum to the 40-bit accumulator range.
	function automatic logic signed [ACC_W-1:0] sat40(input logic signed [WIDE_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if ((&v[WIDE_W-1:ACC_W-1]) || !(|v[WIDE_W-1:ACC_W-1])) begin
			r = v[ACC_W-1:0];
		end else if (v[WIDE_W-1]) begin
			r = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(ACC_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

@@ hdl/hpss_if.sv @@
// ----------------------------------------------------------------------------
// hpss_if: valid/ready channels of the segmenter
// Path element channel and found-site channel, each with source and sink views.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hpss_path_if;
	import hpss_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [STATE_W-1:0]       path_state;
	logic [BASE_W-1:0]        base_code;
	logic signed [LOGV_W-1:0] path_logv;
	logic signed [LOGV_W-1:0] null_logv;
	logic                     end_of_sequence;
	logic                     strand_flag;
	logic [SEQ_W-1:0]         sequence_number;
	logic [TBL_IDX_W-1:0]     table_index;
	logic signed [LOGV_W-1:0] table_value;

	modport source (
		output valid, command, path_state, base_code, path_logv, null_logv,
		       end_of_sequence, strand_flag, sequence_number, table_index, table_value,
		input  ready
	);
	modport sink (
		input  valid, command, path_state, base_code, path_logv, null_logv,
		       end_of_sequence, strand_flag, sequence_number, table_index, table_value,
		output ready
	);
endinterface

interface hpss_site_if;
	import hpss_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [SEQ_W-1:0]        site_sequence;
	logic                    site_strand;
	logic [POS_W-1:0]        site_first;
	logic [POS_W-1:0]        site_last;
	logic signed [ACC_W-1:0] site_score;
	logic [POS_W-1:0]        coord_one;
	logic [POS_W-1:0]        coord_two;
	logic [POS_W-1:0]        coord_three;
	logic [POS_W-1:0]        coord_four;
	logic [POS_W-1:0]        coord_five;
	logic [POS_W-1:0]        coord_six;

	modport source (
		output valid, site_sequence, site_strand, site_first, site_last, site_score,
		       coord_one, coord_two, coord_three, coord_four, coord_five, coord_six,
		input  ready
	);
	modport sink (
		input  valid, site_sequence, site_strand, site_first, site_last, site_score,
		       coord_one, coord_two, coord_three, coord_four, coord_five, coord_six,
		output ready
	);
endinterface

@@ hdl/hpss_front.sv @@
// ----------------------------------------------------------------------------
// hpss_front: intake of the segmenter
// Takes items, writes table entries and turns path elements into queue entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpss_front (
	input  logic                             clk,
	input  logic                             arst_n,
	hpss_path_if.sink                        path,
	input  logic signed [hpss_pkg::LOGV_W-1:0] null_self,
	input  logic                             q_full,
	output logic                             push,
	output hpss_pkg::elem_t                  push_data
);
	import hpss_pkg::*;

	logic signed [LOGV_W-1:0] emis_q [TBL_DEPTH];
	logic [BASE_W-1:0]        prev_base_q;
	logic                     accept;
	logic                     is_table;
	logic [TBL_IDX_W-1:0]     rd_idx;

	assign path.ready = !q_full;
	assign accept     = path.valid && path.ready;
	assign is_table   = (cmd_t'(path.command) == CMD_TABLE);
	assign push       = accept && !is_table;

	// The entry index is the previous base plus four times the current base.
	assign rd_idx = {path.base_code, prev_base_q};

	always_comb begin
		push_data.state     = path.path_state;
		push_data.path_logv = path.path_logv;
		push_data.null_logv = path.null_logv;
		push_data.step      = STEP_W'(emis_q[rd_idx]) + STEP_W'(null_self);
		push_data.eos       = path.end_of_sequence;
		push_data.strand    = path.strand_flag;
		push_data.seq       = path.sequence_number;
	end

	always_ff @(posedge clk) begin
		if (accept && is_table) begin
			emis_q[path.table_index] <= path.table_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_base_q <= '0;
		end else if (push) begin
			prev_base_q <= path.end_of_sequence ? '0 : path.base_code;
		end
	end

endmodule

@@ hdl/hpss_queue.sv @@
// ----------------------------------------------------------------------------
// hpss_queue: short FIFO between intake and site tracking
// Holds queued path elements so each side can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpss_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hpss_pkg::elem_t push_data,
	input  logic            pop,
	output hpss_pkg::elem_t head,
	output logic            full,
	output logic            empty
);
	import hpss_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	elem_t           mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/hpss_back.sv @@
// ----------------------------------------------------------------------------
// hpss_back: site tracking and result output
// One path element a cycle unless stalled; scores and presents each site.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpss_back #(
	parameter int MAX_LENGTH = 65535
) (
	input  logic            clk,
	input  logic            arst_n,
	input  hpss_pkg::cfg_t  cfg,
	input  hpss_pkg::elem_t head,
	input  logic            q_empty,
	output logic            pop,
	hpss_site_if.source     site
);
	import hpss_pkg::*;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);

	// Sequence and site state.
	logic [POS_W-1:0]                 pos_q, pos_n, pos_cur;
	logic [STATE_W-1:0]               prev_state_q, prev_state_n;
	logic signed [LOGV_W-1:0]         prev_path_q, prev_path_n;
	logic signed [LOGV_W-1:0]         prev_null_q, prev_null_n;
	logic                             inside_q, inside_n;
	logic [POS_W-1:0]                 start_q, start_n;
	logic signed [ACC_W-1:0]          acc_q, acc_n;
	logic [STATE_W-1:0]               await_q, await_n;
	logic [NUM_COORDS-1:0][POS_W-1:0] coords_q, coords_n;

	logic    emit;
	emit_t   emit_rec;
	emit_t   emit_s1;
	logic    valid_s1;
	result_t res_q;
	logic    out_valid_q;
	logic    out_load;
	logic    s1_free;
	logic    hit;

	assign out_load = valid_s1 && (!out_valid_q || site.ready);
	assign s1_free  = !valid_s1 || out_load;
	assign pop      = !q_empty && s1_free;

	always_comb begin
		pos_cur      = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;
		pos_n        = pos_cur;
		prev_state_n = head.state;
		prev_path_n  = head.path_logv;
		prev_null_n  = head.null_logv;
		inside_n     = inside_q;
		start_n      = start_q;
		acc_n        = acc_q;
		await_n      = await_q;
		coords_n     = coords_q;
		emit         = 1'b0;
		hit          = 1'b0;
		emit_rec.seq    = head.seq;
		emit_rec.strand = head.strand;
		emit_rec.first  = start_q;
		emit_rec.last   = pos_cur;
		emit_rec.path   = head.path_logv;
		emit_rec.acc    = acc_q;
		emit_rec.coords = coords_q;

		if (inside_q) begin
			if (prev_state_q == S_LAST && head.state == S_NULL) begin
				// Six then null: the site closed on the element before.
				emit          = 1'b1;
				emit_rec.last = (pos_cur > POS_W'(1)) ? pos_cur - 1'b1 : pos_cur;
				emit_rec.path = prev_path_q;
				inside_n      = 1'b0;
				start_n       = '0;
				acc_n         = '0;
				await_n       = S_FIRST_COORD;
				coords_n      = '0;
			end else begin
				acc_n = sat40(WIDE_W'(acc_q) + WIDE_W'(head.step));
				for (int j = 0; j < NUM_COORDS; j++) begin
					if (await_q <= S_LAST && head.state == await_q &&
					    await_q == STATE_W'(j + 1)) begin
						coords_n[j] = pos_cur;
						hit         = 1'b1;
					end
				end
				if (hit) begin
					await_n = await_q + 1'b1;
				end
				if (head.eos) begin
					// A site that runs into a trailing null is dropped.
					emit            = (head.state != S_NULL);
					emit_rec.acc    = acc_n;
					emit_rec.coords = coords_n;
					inside_n        = 1'b0;
					start_n         = '0;
					acc_n           = '0;
					await_n         = S_FIRST_COORD;
					coords_n        = '0;
				end
			end
		end else if (prev_state_q == S_NULL && head.state == S_START) begin
			inside_n = 1'b1;
			start_n  = pos_cur;
			await_n  = S_FIRST_COORD;
			coords_n = '0;
			if (pos_q == '0) begin
				acc_n = ACC_W'(cfg.null_init);
			end else begin
				acc_n = sat40(WIDE_W'(prev_null_q) + WIDE_W'(head.step));
			end
			if (head.eos) begin
				// A site that opens on the last element also closes there.
				emit            = 1'b1;
				emit_rec.first  = pos_cur;
				emit_rec.acc    = acc_n;
				emit_rec.coords = '0;
				inside_n        = 1'b0;
				start_n         = '0;
				acc_n           = '0;
				coords_n        = '0;
			end
		end

		if (head.eos) begin
			pos_n        = '0;
			prev_state_n = S_NULL;
			prev_path_n  = '0;
			prev_null_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			prev_state_q <= S_NULL;
			prev_path_q  <= '0;
			prev_null_q  <= '0;
			inside_q     <= 1'b0;
			start_q      <= '0;
			acc_q        <= '0;
			await_q      <= S_FIRST_COORD;
			coords_q     <= '0;
		end else if (pop) begin
			pos_q        <= pos_n;
			prev_state_q <= prev_state_n;
			prev_path_q  <= prev_path_n;
			prev_null_q  <= prev_null_n;
			inside_q     <= inside_n;
			start_q      <= start_n;
			acc_q        <= acc_n;
			await_q      <= await_n;
			coords_q     <= coords_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= emit;
			end else if (out_load) begin
				valid_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (site.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			emit_s1 <= emit_rec;
		end
		if (out_load) begin
			res_q.seq    <= emit_s1.seq;
			res_q.strand <= emit_s1.strand;
			res_q.first  <= emit_s1.first;
			res_q.last   <= emit_s1.last;
			res_q.score  <= sat40(WIDE_W'(emit_s1.path) - WIDE_W'(emit_s1.acc) -
			                      WIDE_W'(cfg.null_self));
			res_q.coords <= emit_s1.coords;
		end
	end

	assign site.valid         = out_valid_q;
	assign site.site_sequence = res_q.seq;
	assign site.site_strand   = res_q.strand;
	assign site.site_first    = res_q.first;
	assign site.site_last     = res_q.last;
	assign site.site_score    = res_q.score;
	assign site.coord_one     = res_q.coords[0];
	assign site.coord_two     = res_q.coords[1];
	assign site.coord_three   = res_q.coords[2];
	assign site.coord_four    = res_q.coords[3];
	assign site.coord_five    = res_q.coords[4];
	assign site.coord_six     = res_q.coords[5];

endmodule

@@ hdl/hmm_path_site_segmenter_core.sv @@
// ----------------------------------------------------------------------------
// hmm_path_site_segmenter_core: finds scored sites in a decoded HMM path
// The site that an item closes is held in emit_s1, then scored into res_q.
// Throughput: one item per cycle while the site output is not stalled.
// Table writes are taken at the same rate and give no result.
// Reset clears all control and sequence state at once; table entries are
// undefined until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmm_path_site_segmenter_core #(
	parameter int MAX_LENGTH  = 65535,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	hpss_path_if.sink                     path,
	hpss_site_if.source                   site,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hpss_pkg::PADDR_W-1:0]  paddr,
	input  logic [hpss_pkg::CFG_W-1:0]    pwdata,
	output logic [hpss_pkg::CFG_W-1:0]    prdata,
	output logic                          pready
);
	import hpss_pkg::*;

	// The block has three parts. The front takes every item: table writes go
	// straight into the emission table, and path elements pick up their
	// null-state step (table entry plus self transition) before they are
	// queued. The back follows the sequence one element per cycle while
	// the output is not stalled, keeps the open site, and scores each
	// finished site in a second stage ahead of the output register.

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic     q_full;
	logic     q_empty;
	logic     push;
	logic     pop;
	elem_t    push_data;
	elem_t    head;

	// Registers sit at byte addresses 0 and 4; address bit 2 picks one.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NULL_SELF: cfg_q.null_self <= pwdata;
				REG_NULL_INIT: cfg_q.null_init <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NULL_SELF: prdata = cfg_q.null_self;
			REG_NULL_INIT: prdata = cfg_q.null_init;
			default:       prdata = '0;
		endcase
	end

	hpss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.path      (path),
		.null_self (cfg_q.null_self),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// The queue lets intake continue while the output side is stalled.
	hpss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	hpss_back #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.site    (site)
	);

endmodule

@@ hdl/hpss_checker.sv @@
// ----------------------------------------------------------------------------
// hpss_checker: port-level checks of the segmenter
// Watches the site channel and attaches itself to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               site_valid,
	input logic               site_ready,
	input logic [15:0]        site_first,
	input logic [15:0]        site_last,
	input logic signed [39:0] site_score,
	input logic [15:0]        coord_one,
	input logic [15:0]        coord_two,
	input logic [15:0]        coord_three,
	input logic [15:0]        coord_four,
	input logic [15:0]        coord_five,
	input logic [15:0]        coord_six
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		site_valid && !site_ready |=> site_valid && $stable(site_score) && $stable(site_last))
		else $error("site item changed while stalled");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		site_valid |-> site_first != 16'd0 && site_last != 16'd0)
		else $error("site position is zero");

	// States are reached in order, so a missing state hides all later ones.
	a_coord_order: assert property (@(posedge clk) disable iff (!arst_n)
		site_valid |-> (coord_one != 16'd0 || coord_two == 16'd0) &&
		               (coord_two != 16'd0 || coord_three == 16'd0) &&
		               (coord_three != 16'd0 || coord_four == 16'd0) &&
		               (coord_four != 16'd0 || coord_five == 16'd0) &&
		               (coord_five != 16'd0 || coord_six == 16'd0))
		else $error("state coordinate reached out of order");

	a_coord_mono: assert property (@(posedge clk) disable iff (!arst_n)
		site_valid |-> (coord_one == 16'd0 || coord_one >= site_first) &&
		               (coord_two == 16'd0 || coord_two >= coord_one) &&
		               (coord_three == 16'd0 || coord_three >= coord_two) &&
		               (coord_four == 16'd0 || coord_four >= coord_three) &&
		               (coord_five == 16'd0 || coord_five >= coord_four) &&
		               (coord_six == 16'd0 || coord_six >= coord_five))
		else $error("state coordinates not ascending");

endmodule

bind hmm_path_site_segmenter_core hpss_checker u_hpss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.site_valid  (site.valid),
	.site_ready  (site.ready),
	.site_first  (site.site_first),
	.site_last   (site.site_last),
	.site_score  (site.site_score),
	.coord_one   (site.coord_one),
	.coord_two   (site.coord_two),
	.coord_three (site.coord_three),
	.coord_four  (site.coord_four),
	.coord_five  (site.coord_five),
	.coord_six   (site.coord_six)
);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hmm_path_site_segmenter_core
// Streams decoded path elements and emission table writes into the core while
// both channels idle at random, predicts every found site from a bit-true
// model of the site tracker, and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import hpss_pkg::*;

	// Positions stop counting at this value in an overlong sequence.
	localparam int MAX_POS = 65535;
	// Range of the 40-bit signed accumulator and score.
	localparam longint ACC_HI = 64'sh0000_007F_FFFF_FFFF;
	localparam longint ACC_LO = -64'sh0000_0080_0000_0000;
	// Cycles allowed after the last expected site before the core counts as idle.
	localparam int SETTLE_CYCLES = 4;
	// Bound on any wait for outstanding sites.
	localparam int DRAIN_LIMIT = 20000;
	// Random items per phase, table writes between elements included.
	localparam int PHASE_ITEMS = 300;
	localparam int NUM_PHASES = 5;

	typedef enum {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_SMALL} fill_t;

	// One item of the path channel as the bench sends it.
	typedef struct {
		cmd_t                command;
		logic [STATE_W-1:0]  state;
		logic [BASE_W-1:0]   base;
		logic [LOGV_W-1:0]   path_logv;
		logic [LOGV_W-1:0]   null_logv;
		logic                eos;
		logic                strand;
		logic [SEQ_W-1:0]    seq;
		logic [TBL_IDX_W-1:0] tidx;
		logic [LOGV_W-1:0]   tval;
	} path_item_t;

	// Site tracker model and the queue of sites it still waits for.
	class site_book;
		longint null_self;
		longint null_init;
		longint emission[TBL_DEPTH];
		int unsigned pos_count;
		int unsigned site_first;
		int unsigned awaited;
		logic [STATE_W-1:0] prev_state;
		logic [BASE_W-1:0] prev_base;
		longint prev_null;
		longint prev_path;
		longint null_acc;
		bit in_site;
		logic [POS_W-1:0] coords[NUM_COORDS];
		result_t expected_sites[$];
		int unsigned mismatches;

		function new();
			null_self = 0;
			null_init = 0;
			foreach (emission[i]) emission[i] = 0;
			mismatches = 0;
			end_sequence();
		endfunction

		function void drop_site();
			in_site = 1'b0;
			site_first = 0;
			null_acc = 0;
			awaited = S_FIRST_COORD;
			foreach (coords[i]) coords[i] = '0;
		endfunction

		function void end_sequence();
			pos_count = 0;
			prev_state = S_NULL;
			prev_base = '0;
			prev_null = 0;
			prev_path = 0;
			drop_site();
		endfunction

		function longint clip40(longint v);
			if (v > ACC_HI) return ACC_HI;
			if (v < ACC_LO) return ACC_LO;
			return v;
		endfunction

		// Null-state cost of moving from the previous base to the current one.
		function longint null_move(logic [BASE_W-1:0] pb, logic [BASE_W-1:0] cb);
			return emission[{cb, pb}] + null_self;
		endfunction

		function void post_site(logic [SEQ_W-1:0] seq, logic strand, int unsigned last,
				longint path);
			result_t r;
			r.seq = seq;
			r.strand = strand;
			r.first = POS_W'(site_first);
			r.last = POS_W'(last);
			r.score = ACC_W'(clip40(path - null_acc - null_self));
			for (int j = 0; j < NUM_COORDS; j++) r.coords[j] = coords[j];
			expected_sites.push_back(r);
		endfunction

		function void set_reg(reg_idx_t r, logic [CFG_W-1:0] v);
			if (r == REG_NULL_SELF) null_self = longint'($signed(v));
			else null_init = longint'($signed(v));
		endfunction

		function void take_item(path_item_t it);
			bit first;
			int unsigned pos;
			longint plogv;
			if (it.command == CMD_TABLE) begin
				emission[it.tidx] = longint'($signed(it.tval));
				return;
			end
			first = (pos_count == 0);
			if (pos_count < MAX_POS) pos_count++;
			pos = pos_count;
			plogv = longint'($signed(it.path_logv));
			if (in_site) begin
				if (prev_state == S_LAST && it.state == S_NULL) begin
					// Six then null closes the site one position back.
					post_site(it.seq, it.strand, pos > 1 ? pos - 1 : pos, prev_path);
					drop_site();
				end else begin
					null_acc = clip40(null_acc + null_move(prev_base, it.base));
					if (awaited <= S_LAST && it.state == awaited) begin
						coords[awaited - 1] = POS_W'(pos);
						awaited++;
					end
					if (it.eos) begin
						// A site running into a trailing null is dropped.
						if (it.state != S_NULL) post_site(it.seq, it.strand, pos, plogv);
						drop_site();
					end
				end
			end else if (prev_state == S_NULL && it.state == S_START) begin
				in_site = 1'b1;
				site_first = pos;
				awaited = S_FIRST_COORD;
				foreach (coords[i]) coords[i] = '0;
				null_acc = first ? null_init : clip40(prev_null + null_move(prev_base, it.base));
				if (it.eos) begin
					post_site(it.seq, it.strand, pos, plogv);
					drop_site();
				end
			end
			if (it.eos) begin
				end_sequence();
			end else begin
				prev_state = it.state;
				prev_base = it.base;
				prev_null = longint'($signed(it.null_logv));
				prev_path = plogv;
			end
		endfunction

		function string describe(result_t r);
			return $sformatf("seq=%0d strand=%0d first=%0d last=%0d score=%0d coords=%h",
				r.seq, r.strand, r.first, r.last, r.score, r.coords);
		endfunction

		function void check_site(result_t got);
			result_t want;
			bit bad;
			if (expected_sites.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected site: %s", describe(got));
				return;
			end
			want = expected_sites.pop_front();
			bad = (got.seq !== want.seq) || (got.strand !== want.strand) ||
				(got.first !== want.first) || (got.last !== want.last) ||
				(got.score !== want.score);
			for (int j = 0; j < NUM_COORDS; j++) bad |= (got.coords[j] !== want.coords[j]);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("site mismatch at %0t", $realtime);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction

		// Any site still waiting at the end was never delivered.
		function void close_run();
			while (expected_sites.size() != 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("missing site: %s", describe(expected_sites[0]));
				void'(expected_sites.pop_front());
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [CFG_W-1:0]    pwdata;
	logic [CFG_W-1:0]    prdata;
	logic                pready;

	hpss_path_if path_ch ();
	hpss_site_if site_ch ();

	hmm_path_site_segmenter_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.path    (path_ch),
		.site    (site_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	site_book book = new();
	// When set, neither side idles; used for the final part of the run.
	bit quiet = 1'b0;
	int unsigned stall_left = 0;
	int unsigned items_sent = 0;

	always #6 clk = ~clk;

	// Every input of the core is known from time zero, with reset asserted.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		path_ch.valid = 1'b0;
		path_ch.command = CMD_PATH;
		path_ch.path_state = S_NULL;
		path_ch.base_code = '0;
		path_ch.path_logv = '0;
		path_ch.null_logv = '0;
		path_ch.end_of_sequence = 1'b0;
		path_ch.strand_flag = 1'b0;
		path_ch.sequence_number = 16'd1;
		path_ch.table_index = '0;
		path_ch.table_value = '0;
		site_ch.ready = 1'b0;
	end

	// The result side stalls in bursts at random, except when quiet.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			site_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 6);
			site_ch.ready <= 1'b0;
		end else begin
			site_ch.ready <= 1'b1;
		end
	end

	// Every accepted site goes straight to the scoreboard.
	initial begin : site_monitor
		result_t got;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && site_ch.valid === 1'b1 && site_ch.ready === 1'b1) begin
				got.seq = site_ch.site_sequence;
				got.strand = site_ch.site_strand;
				got.first = site_ch.site_first;
				got.last = site_ch.site_last;
				got.score = site_ch.site_score;
				got.coords[0] = site_ch.coord_one;
				got.coords[1] = site_ch.coord_two;
				got.coords[2] = site_ch.coord_three;
				got.coords[3] = site_ch.coord_four;
				got.coords[4] = site_ch.coord_five;
				got.coords[5] = site_ch.coord_six;
				book.check_site(got);
			end
		end
	end

	// Log scores lean toward the ends of the range so that saturation shows up.
	function automatic logic [LOGV_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			default: return $urandom();
		endcase
	endfunction

	// A path element; the table fields ride along with random content.
	function automatic path_item_t element(logic [STATE_W-1:0] st, logic eos, logic strand,
			logic [SEQ_W-1:0] seq);
		path_item_t it;
		it.command = CMD_PATH;
		it.state = st;
		it.base = BASE_W'($urandom_range(0, 3));
		it.path_logv = rand_word();
		it.null_logv = rand_word();
		it.eos = eos;
		it.strand = strand;
		it.seq = seq;
		it.tidx = TBL_IDX_W'($urandom_range(0, 15));
		it.tval = $urandom();
		return it;
	endfunction

	// A table write; the path fields are random and must be ignored by the core.
	function automatic path_item_t table_entry(logic [TBL_IDX_W-1:0] idx,
			logic [LOGV_W-1:0] val);
		path_item_t it;
		it = element(STATE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), SEQ_W'($urandom_range(1, 65535)));
		it.command = CMD_TABLE;
		it.tidx = idx;
		it.tval = val;
		return it;
	endfunction

	// Presents one item from a falling edge and returns at the falling edge after
	// it was taken. A gap lowers valid first; valid is never lowered and raised
	// within one step.
	task automatic send_item(path_item_t it);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			path_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		path_ch.valid <= 1'b1;
		path_ch.command <= it.command;
		path_ch.path_state <= it.state;
		path_ch.base_code <= it.base;
		path_ch.path_logv <= it.path_logv;
		path_ch.null_logv <= it.null_logv;
		path_ch.end_of_sequence <= it.eos;
		path_ch.strand_flag <= it.strand;
		path_ch.sequence_number <= it.seq;
		path_ch.table_index <= it.tidx;
		path_ch.table_value <= it.tval;
		do @(posedge clk); while (path_ch.ready !== 1'b1);
		book.take_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Holds the sender until every predicted site has arrived, then lets the
	// pipeline settle since the last items may have produced nothing.
	task automatic drain();
		int unsigned waited = 0;
		path_ch.valid <= 1'b0;
		while (book.expected_sites.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Setup and access phase; the register changes at the edge with pready high.
	// The bus then idles before the next transfer may start.
	task automatic write_reg(reg_idx_t r, logic [CFG_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({r, 2'b00});
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		book.set_reg(r, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(logic [CFG_W-1:0] self_v, logic [CFG_W-1:0] init_v);
		drain();
		write_reg(REG_NULL_SELF, self_v);
		write_reg(REG_NULL_INIT, init_v);
	endtask

	// Rewrites all sixteen emission entries, so no later read hits an unwritten one.
	task automatic fill_table(fill_t mode);
		logic [LOGV_W-1:0] v;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			case (mode)
				FILL_MAX: v = 32'h7FFF_FFFF;
				FILL_MIN: v = 32'h8000_0000;
				FILL_SMALL: v = ~LOGV_W'($urandom_range(0, 32'h0008_0000));
				default: v = rand_word();
			endcase
			send_item(table_entry(TBL_IDX_W'(i), v));
		end
	endtask

	// Sends a list of states as one sequence, end of sequence on the last one.
	// Now and then a table write slips in between elements.
	task automatic send_states(logic [STATE_W-1:0] states[$], logic [SEQ_W-1:0] seq,
			logic strand);
		foreach (states[i]) begin
			if ($urandom_range(0, 39) == 0)
				send_item(table_entry(TBL_IDX_W'($urandom_range(0, 15)), rand_word()));
			send_item(element(states[i], i == states.size() - 1, strand, seq));
		end
	endtask

	// Mostly well-formed sequences: a few null elements, then sites that walk
	// from state 0 through 1..6 with repeats and stray states, each closed by a
	// null. The last site may be cut short so that the sequence end closes it,
	// sometimes on a trailing null that drops it. One sequence in ten is noise.
	task automatic send_sequence(bit long_sites);
		logic [STATE_W-1:0] states[$];
		logic [SEQ_W-1:0] seq;
		logic strand;
		int sites;
		int reps;
		int site_at;
		int cut;
		seq = SEQ_W'($urandom_range(1, 65535));
		strand = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 20)) states.push_back(STATE_W'($urandom_range(0, 7)));
		end else begin
			repeat ($urandom_range(0, 2)) states.push_back(S_NULL);
			sites = $urandom_range(1, 3);
			for (int k = 0; k < sites; k++) begin
				site_at = states.size();
				states.push_back(S_START);
				for (int s = S_FIRST_COORD; s <= S_LAST; s++) begin
					if (long_sites && $urandom_range(0, 3) == 0) reps = $urandom_range(10, 60);
					else reps = $urandom_range(1, 3);
					repeat (reps) states.push_back(STATE_W'(s));
					if ($urandom_range(0, 7) == 0)
						states.push_back(STATE_W'($urandom_range(0, 7)));
				end
				if (k == sites - 1 && $urandom_range(0, 2) == 0) begin
					cut = $urandom_range(site_at, states.size() - 1);
					while (states.size() > cut + 1) void'(states.pop_back());
					if ($urandom_range(0, 1) == 0) states.push_back(S_NULL);
				end else begin
					repeat ($urandom_range(1, 3)) states.push_back(S_NULL);
				end
			end
		end
		send_states(states, seq, strand);
	endtask

	initial begin : stimulus
		path_item_t it;
		logic [STATE_W-1:0] states[$];
		int unsigned goal;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: extreme registers, a filled table, then the special cases.
		write_reg(REG_NULL_SELF, 32'h8000_0000);
		write_reg(REG_NULL_INIT, 32'h7FFF_FFFF);
		fill_table(FILL_SMALL);

		// A site that starts and ends on the only element of a sequence.
		it = element(S_START, 1'b1, 1'b0, 16'd1);
		it.path_logv = 32'h8000_0000;
		send_item(it);

		// A full walk through states 0..6, closed by a null on the last element.
		for (int s = S_START; s <= S_NULL; s++) begin
			it = element(STATE_W'(s), s == S_NULL, 1'b1, 16'hFFFF);
			it.base = BASE_W'(s);
			if (s == S_LAST) it.path_logv = 32'h7FFF_FFFF;
			if (s == S_START) it.null_logv = 32'h8000_0000;
			send_item(it);
		end

		// Null and state 0 inside a site start nothing; the site ends on state 6
		// at the sequence end with only the first coordinate reached.
		states = '{S_NULL, S_START, S_NULL, S_START, S_FIRST_COORD, S_LAST};
		send_states(states, 16'h5A5A, 1'b0);

		// A site that runs into a trailing null at the sequence end is dropped.
		states = '{S_NULL, S_START, S_LAST - 3'd1, S_NULL};
		send_states(states, 16'hA5A5, 1'b1);

		// Random part in phases. Each phase waits for every site, writes both
		// registers and refills the table; the last phase runs without idling.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: configure('0, '0);
				1: configure(32'h7FFF_FFFF, 32'h8000_0000);
				2: configure(32'h8000_0000, 32'h7FFF_FFFF);
				3: configure($urandom(), $urandom());
				default: configure(~CFG_W'($urandom_range(0, 32'h0004_0000)),
					~CFG_W'($urandom_range(0, 32'h0010_0000)));
			endcase
			quiet = (p == NUM_PHASES - 1);
			case (p)
				1: fill_table(FILL_MAX);
				2: fill_table(FILL_MIN);
				4: fill_table(FILL_SMALL);
				default: fill_table(FILL_RANDOM);
			endcase
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) send_sequence(p == 1 || p == 2);
		end

		// Wait for the last sites, then judge the run.
		drain();
		book.close_run();
		if (book.mismatches == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin : watchdog
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/hpss_pkg.sv
hdl/hpss_if.sv
hdl/hpss_front.sv
hdl/hpss_queue.sv
hdl/hpss_back.sv
hdl/hmm_path_site_segmenter_core.sv
hdl/hpss_checker.sv
sim/testbench.sv
